// File: hdl/nnr_pkg.sv
package nnr_pkg;

  // Frame store geometry and fixed-point format
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 14;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int POS_W      = 9;
  localparam int ANGLE_W    = 16;
  localparam int OFFSET_W   = 26;
  localparam int SIZE_W     = 10;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Product of a Q1.14 factor and a zero-extended coordinate, then the
  // three-term sum that maps a destination coordinate to the source.
  localparam int PROD_W     = ANGLE_W + POS_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int INT_W      = SUM_W - FRAC_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = OFFSET_W;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [ANGLE_W-1:0] COS_RESET    = ANGLE_W'(1 << FRAC_BITS);
  localparam logic [SIZE_W-1:0]  WIDTH_RESET  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET = SIZE_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_THETA  = 3'd0,
    CFG_SIN_THETA  = 3'd1,
    CFG_OFFSET_X   = 3'd2,
    CFG_OFFSET_Y   = 3'd3,
    CFG_SRC_WIDTH  = 3'd4,
    CFG_SRC_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic             out_outside;
  } out_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  cos_theta;
    logic [ANGLE_W-1:0]  sin_theta;
    logic [OFFSET_W-1:0] offset_x;
    logic [OFFSET_W-1:0] offset_y;
    logic [SIZE_W-1:0]   src_width;
    logic [SIZE_W-1:0]   src_height;
  } cfg_t;

  // Frame store access issued by the mapping pipeline
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              sample;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
  } req_t;

endpackage

// File: hdl/nnr_map.sv
module nnr_map (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nnr_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  input  nnr_pkg::in_t  item_i,
  output nnr_pkg::req_t req_o
);
  import nnr_pkg::*;

  localparam logic signed [SUM_W-1:0] NEG_ONE = SUM_W'(-(1 << FRAC_BITS));

  // Stage 1: captured transaction
  logic s1_valid_q;
  in_t  s1_q;

  // Stage 2: products
  logic                     s2_valid_q;
  in_t                      s2_q;
  logic signed [PROD_W-1:0] cx_q, sy_q, sx_q, cy_q;
  logic signed [PROD_W-1:0] cx_d, sy_d, sx_d, cy_d;

  // Stage 3: mapped fixed-point coordinates
  logic                    s3_valid_q;
  in_t                     s3_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic signed [SUM_W-1:0] sum_x_d, sum_y_d;

  // Stage 4: frame store request
  req_t req_q, req_d;

  always_comb begin
    logic signed [PROD_W-1:0] cos_e, sin_e, px_e, py_e;
    cos_e = PROD_W'($signed(cfg_i.cos_theta));
    sin_e = PROD_W'($signed(cfg_i.sin_theta));
    px_e  = PROD_W'($signed({1'b0, s1_q.pos_x}));
    py_e  = PROD_W'($signed({1'b0, s1_q.pos_y}));
    cx_d  = cos_e * px_e;
    sy_d  = sin_e * py_e;
    sx_d  = sin_e * px_e;
    cy_d  = cos_e * py_e;
  end

  always_comb begin
    logic signed [SUM_W-1:0] off_x, off_y;
    off_x   = SUM_W'($signed(cfg_i.offset_x));
    off_y   = SUM_W'($signed(cfg_i.offset_y));
    sum_x_d = SUM_W'(cx_q) - SUM_W'(sy_q) + off_x;
    sum_y_d = SUM_W'(sx_q) + SUM_W'(cy_q) + off_y;
  end

  always_comb begin
    logic [INT_W-1:0]  w_lim, h_lim, x_int, y_int;
    logic              x_in, y_in, load_in;
    logic [ADDR_W-1:0] smp_addr, load_addr;
    w_lim = (cfg_i.src_width > SIZE_W'(MAX_WIDTH)) ? INT_W'(MAX_WIDTH)
                                                    : INT_W'(cfg_i.src_width);
    h_lim = (cfg_i.src_height > SIZE_W'(MAX_HEIGHT)) ? INT_W'(MAX_HEIGHT)
                                                      : INT_W'(cfg_i.src_height);
    // Truncate toward zero: a negative value above -1 lands on column 0
    x_int = sum_x_q[SUM_W-1] ? '0 : sum_x_q[SUM_W-1:FRAC_BITS];
    y_int = sum_y_q[SUM_W-1] ? '0 : sum_y_q[SUM_W-1:FRAC_BITS];
    x_in  = (!sum_x_q[SUM_W-1] || (sum_x_q > NEG_ONE)) && (x_int < w_lim);
    y_in  = (!sum_y_q[SUM_W-1] || (sum_y_q > NEG_ONE)) && (y_int < h_lim);
    smp_addr  = ADDR_W'(y_int[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
              + ADDR_W'(x_int[COL_W-1:0]);
    load_addr = ADDR_W'(s3_q.pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s3_q.pos_x);
    load_in   = ({1'b0, s3_q.pos_x} < (POS_W + 1)'(MAX_WIDTH))
             && ({1'b0, s3_q.pos_y} < (POS_W + 1)'(MAX_HEIGHT));

    req_d.sample = s3_valid_q && (s3_q.func == FUNC_SAMPLE);
    req_d.rd_en  = req_d.sample && x_in && y_in;
    req_d.wr_en  = s3_valid_q && (s3_q.func == FUNC_LOAD) && load_in;
    req_d.addr   = (s3_q.func == FUNC_LOAD) ? load_addr : smp_addr;
    req_d.pixel  = s3_q.pixel_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      req_q        <= '0;
    end else begin
      s1_valid_q   <= valid_i;
      s2_valid_q   <= s1_valid_q;
      s3_valid_q   <= s2_valid_q;
      req_q        <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= item_i;
    s2_q       <= s1_q;
    cx_q       <= cx_d;
    sy_q       <= sy_d;
    sx_q       <= sx_d;
    cy_q       <= cy_d;
    s3_q       <= s2_q;
    sum_x_q    <= sum_x_d;
    sum_y_q    <= sum_y_d;
  end

  assign req_o = req_q;

endmodule

// File: hdl/nnr_frame_store.sv
module nnr_frame_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nnr_pkg::req_t req_i,
  output logic          res_valid_o,
  output nnr_pkg::out_t res_o
);
  import nnr_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_q;
  logic             res_valid_q;
  logic             outside_q;

  // Loads and samples share one pipeline slot, so at most one access a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.pixel;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      outside_q   <= 1'b1;
    end else begin
      res_valid_q <= req_i.sample;
      outside_q   <= !req_i.rd_en;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_o.out_outside = outside_q;
  assign res_o.out_value   = outside_q ? '0 : rd_data_q;

endmodule

// File: hdl/nearest_neighbor_rotator_unit.sv
// Nearest-neighbor image rotator with an on-chip 512 x 512 x 8 frame store.
// Input: a transaction is taken on each rising edge with start_i high and
// busy_o low. busy_o stays low, so one transaction per clock is accepted.
// func = load writes pixel_value at (pos_x, pos_y) and gives no result.
// func = sample maps (pos_x, pos_y) back into the source image and returns
// the stored pixel, or zero with out_outside set when it falls outside.
// Output: res_valid_o is high for exactly one cycle per sample, in acceptance order.
// The receiver cannot stall; results must be taken when strobed.
// Throughput is one transaction per cycle: four products, the coordinate
// sums, the range check and one frame store access each take one stage, and
// the store sees a single access per cycle, so loads and samples keep order.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data;
// cfg_ready_o is always high. Write registers only while no sample is in
// flight. Indexes past the last register are ignored.
// Reset: registers return to identity rotation, zero offset and full size;
// the frame store is not cleared and must be loaded before it is sampled.
module nearest_neighbor_rotator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  nnr_pkg::in_t                       in_i,
  output logic                               res_valid_o,
  output nnr_pkg::out_t                      res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nnr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nnr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import nnr_pkg::*;

  cfg_t cfg_q, cfg_d;
  req_t req;
  logic accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COS_THETA:  cfg_d.cos_theta  = cfg_data_i[ANGLE_W-1:0];
        CFG_SIN_THETA:  cfg_d.sin_theta  = cfg_data_i[ANGLE_W-1:0];
        CFG_OFFSET_X:   cfg_d.offset_x   = cfg_data_i[OFFSET_W-1:0];
        CFG_OFFSET_Y:   cfg_d.offset_y   = cfg_data_i[OFFSET_W-1:0];
        CFG_SRC_WIDTH:  cfg_d.src_width  = cfg_data_i[SIZE_W-1:0];
        CFG_SRC_HEIGHT: cfg_d.src_height = cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_theta  <= COS_RESET;
      cfg_q.sin_theta  <= '0;
      cfg_q.offset_x   <= '0;
      cfg_q.offset_y   <= '0;
      cfg_q.src_width  <= WIDTH_RESET;
      cfg_q.src_height <= HEIGHT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nnr_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (accept),
    .item_i  (in_i),
    .req_o   (req)
  );

  nnr_frame_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Every accepted sample yields a result strobe
  a_sample_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == FUNC_SAMPLE) |-> ##5 res_valid_o)
    else $error("sample transaction produced no result");

  // Loads never yield a strobe
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == FUNC_LOAD) |-> ##5 !res_valid_o)
    else $error("load transaction produced a result");

  // No strobe without an earlier accepted sample
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept && in_i.func == FUNC_SAMPLE, 5))
    else $error("result strobe without a sample transaction");

  // An in-range result comes from a read the store actually issued
  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.out_outside) |-> $past(req.rd_en && !req.wr_en))
    else $error("in-range result without a frame store read");

endmodule
